FILE: hdl/cfa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfa_pkg: shared definitions for the contiguous frame allocator
// Command, status and register codes, defaults and the frame table entry.
// ---------------------------------------------------------------------------
package cfa_pkg;

    localparam int NUM_FRAMES_DEF = 256;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 9;
    localparam int OWNER_W  = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [ADDR_W-1:0] LIMIT_GUARD = 32'd4096;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET_USER = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_TABLE = 2'd2;

    localparam logic [OWNER_W-1:0] OWNER_USER = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_LIMIT = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST  = 32'd0;
    localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 9'd256;
    localparam logic [ADDR_W-1:0]  ADDRESS_LIMIT_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               used;
        logic [OWNER_W-1:0] owner;
        logic [COUNT_W-1:0] run_len;
    } frame_entry_t;

endpackage

FILE: hdl/contiguous_frame_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// contiguous_frame_allocator: first-fit allocator of contiguous page frames
// Per-frame table in one memory, walked one frame a cycle by a sequencer.
// ---------------------------------------------------------------------------
// Commands are taken one at a time: s_tready is low from acceptance until the
//   result is loaded into the output register.
// Reset: aresetn (synchronous, active low) starts a clearing pass over every
//   frame table entry; s_tready stays low until done.
module contiguous_frame_allocator #(
    parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = cfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Command channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: page_count[8:0], owner[10:9], address[42:11], zero pad
    input  logic [cfa_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: command[1:0]
    input  logic [cfa_pkg::CMD_W-1:0]         s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, low bit up: address_res[31:0], status[33:32], freed_count[42:34],
    // zero pad
    output logic [cfa_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int FIDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int MF_W       = FIDX_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int OFF_W      = cfa_pkg::ADDR_W - PAGE_SHIFT;
    localparam int SUM_W      = cfa_pkg::ADDR_W + 1;
    localparam int PAD_W      = cfa_pkg::OUT_DATA_W - cfa_pkg::ADDR_W
                                - cfa_pkg::STATUS_W - cfa_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LIMIT,
        ST_MARK,
        ST_FREE_CHK,
        ST_FREE_RD,
        ST_FREE_LEN,
        ST_FREE_CLR,
        ST_RESULT
    } state_t;

    // Configuration registers
    logic [cfa_pkg::ADDR_W-1:0]  base_reg;
    logic [cfa_pkg::COUNT_W-1:0] fiu_reg;
    logic [cfa_pkg::ADDR_W-1:0]  limit_reg;

    // Sequencer registers
    state_t                       state_reg, state_next;
    logic [cfa_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [cfa_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [cfa_pkg::OWNER_W-1:0]  owner_reg, owner_next;
    logic [cfa_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [cfa_pkg::ADDR_W-1:0]   lim_reg, lim_next;
    logic [MF_W-1:0]              ptr_reg, ptr_next;
    logic                         dv_reg, dv_next;
    logic [FIDX_W-1:0]            didx_reg, didx_next;
    logic [cfa_pkg::COUNT_W-1:0]  run_reg, run_next;
    logic [FIDX_W-1:0]            first_reg, first_next;
    logic [cfa_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [cfa_pkg::COUNT_W-1:0]  len_reg, len_next;
    logic [cfa_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [cfa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [cfa_pkg::ADDR_W-1:0]   m_addr_reg, m_addr_next;
    logic [cfa_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [cfa_pkg::COUNT_W-1:0]  m_freed_reg, m_freed_next;

    // Frame table
    cfa_pkg::frame_entry_t mem [NUM_FRAMES];
    cfa_pkg::frame_entry_t rd_q;
    logic                  wr_en;
    logic [FIDX_W-1:0]     wr_addr;
    cfa_pkg::frame_entry_t wr_data;

    // Combinational helpers
    logic [MF_W-1:0]    frames;
    logic               issue;
    logic               s_fire;
    logic [SUM_W-1:0]   run_addr;
    logic [SUM_W-1:0]   free_diff;
    logic [OFF_W-1:0]   free_off;

    // Managed frame count, clamped to the table depth
    assign frames = (32'(fiu_reg) > 32'(NUM_FRAMES)) ? MF_W'(NUM_FRAMES) : MF_W'(fiu_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    // Issue a table read each cycle of a scan until the managed frames run out
    assign issue    = (state_reg == ST_SCAN) && (ptr_reg < frames);

    assign run_addr  = {1'b0, base_reg} + (SUM_W'(first_reg) << PAGE_SHIFT);
    assign free_diff = {1'b0, addr_reg} - {1'b0, base_reg};
    assign free_off  = free_diff[cfa_pkg::ADDR_W-1:PAGE_SHIFT];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_freed_reg, m_status_reg, m_addr_reg};

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[ptr_reg[FIDX_W-1:0]];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= cfa_pkg::BASE_ADDRESS_RST;
            fiu_reg   <= cfa_pkg::FRAMES_IN_USE_RST;
            limit_reg <= cfa_pkg::ADDRESS_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cfa_pkg::REG_BASE_ADDRESS:  base_reg  <= cfg_wr_data;
                cfa_pkg::REG_FRAMES_IN_USE: fiu_reg   <= cfg_wr_data[cfa_pkg::COUNT_W-1:0];
                cfa_pkg::REG_ADDRESS_LIMIT: limit_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer next-state logic
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        owner_next      = owner_reg;
        addr_next       = addr_reg;
        lim_next        = lim_reg;
        ptr_next        = ptr_reg;
        dv_next         = issue;
        didx_next       = ptr_reg[FIDX_W-1:0];
        run_next        = run_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        m_freed_next    = m_freed_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[FIDX_W-1:0];
        wr_data         = '0;

        if (issue) begin
            ptr_next = ptr_reg + MF_W'(1);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // Zero one entry per cycle after reset
                wr_en    = 1'b1;
                ptr_next = ptr_reg + MF_W'(1);
                if (ptr_reg[FIDX_W-1:0] == FIDX_W'(NUM_FRAMES - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next        = s_tuser;
                    count_next      = s_tdata[8:0];
                    owner_next      = s_tdata[10:9];
                    addr_next       = s_tdata[42:11];
                    lim_next        = (limit_reg >= cfa_pkg::LIMIT_GUARD)
                                      ? (limit_reg - cfa_pkg::LIMIT_GUARD) : '0;
                    ptr_next        = '0;
                    run_next        = '0;
                    cnt_next        = '0;
                    res_addr_next   = '0;
                    res_status_next = cfa_pkg::ST_OK;
                    unique case (s_tuser)
                        cfa_pkg::CMD_ALLOC: begin
                            res_status_next = cfa_pkg::ST_NO_RUN;
                            state_next = (s_tdata[8:0] == '0) ? ST_RESULT : ST_SCAN;
                        end
                        cfa_pkg::CMD_FREE:       state_next = ST_FREE_CHK;
                        cfa_pkg::CMD_RESET_USER: state_next = ST_SCAN;
                        default:                 state_next = ST_RESULT;
                    endcase
                end
            end

            ST_SCAN: begin
                if (dv_reg) begin
                    if (cmd_reg == cfa_pkg::CMD_ALLOC) begin
                        // First fit: extend the free run, restart on a used frame
                        if (!rd_q.used) begin
                            if (run_reg == '0) begin
                                first_next = didx_reg;
                            end
                            run_next = run_reg + cfa_pkg::COUNT_W'(1);
                            if (run_reg == count_reg - cfa_pkg::COUNT_W'(1)) begin
                                state_next = ST_LIMIT;
                            end
                        end else begin
                            run_next = '0;
                        end
                    end else if (rd_q.owner == cfa_pkg::OWNER_USER) begin
                        // Drop a user frame
                        wr_en    = 1'b1;
                        wr_addr  = didx_reg;
                        cnt_next = cnt_reg + cfa_pkg::COUNT_W'(1);
                    end
                end
                if (!dv_reg && !issue) begin
                    state_next = ST_RESULT;
                end
            end

            ST_LIMIT: begin
                // Check the run's base address against the limit guard
                ptr_next = MF_W'(first_reg);
                cnt_next = '0;
                if (run_addr < {1'b0, lim_reg}) begin
                    res_addr_next   = run_addr[cfa_pkg::ADDR_W-1:0];
                    res_status_next = cfa_pkg::ST_OK;
                    state_next      = ST_MARK;
                end else begin
                    state_next = ST_RESULT;
                end
            end

            ST_MARK: begin
                // Mark the run used; the head frame carries the run length
                wr_en         = 1'b1;
                wr_data.used  = 1'b1;
                wr_data.owner = owner_reg;
                wr_data.run_len = (cnt_reg == '0) ? count_reg : '0;
                ptr_next = ptr_reg + MF_W'(1);
                cnt_next = cnt_reg + cfa_pkg::COUNT_W'(1);
                if (cnt_reg == count_reg - cfa_pkg::COUNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_RESULT;
                end
            end

            ST_FREE_CHK: begin
                // Address to frame index; reject anything outside the managed frames
                ptr_next = MF_W'(free_off);
                if (free_diff[cfa_pkg::ADDR_W] || (SUM_W'(free_off) >= SUM_W'(frames))) begin
                    res_status_next = cfa_pkg::ST_OUT_TABLE;
                    state_next      = ST_RESULT;
                end else begin
                    state_next = ST_FREE_RD;
                end
            end

            ST_FREE_RD: begin
                state_next = ST_FREE_LEN;
            end

            ST_FREE_LEN: begin
                len_next   = rd_q.run_len;
                state_next = ST_FREE_CLR;
            end

            ST_FREE_CLR: begin
                // Release the recorded run, stopping at the last managed frame
                if ((cnt_reg < len_reg) && (ptr_reg < frames)) begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + MF_W'(1);
                    cnt_next = cnt_reg + cfa_pkg::COUNT_W'(1);
                end else begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT: begin
                // Hold until the output register is free, then load it
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    m_freed_next  = (cmd_reg == cfa_pkg::CMD_FREE
                                     || cmd_reg == cfa_pkg::CMD_RESET_USER) ? cnt_reg : '0;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        count_reg      <= count_next;
        owner_reg      <= owner_next;
        addr_reg       <= addr_next;
        lim_reg        <= lim_next;
        didx_reg       <= didx_next;
        run_reg        <= run_next;
        first_reg      <= first_next;
        cnt_reg        <= cnt_next;
        len_reg        <= len_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
        m_freed_reg    <= m_freed_next;
    end

endmodule
